/* src/nwsc_pkg.sv */
// shared constants and types for the nose wheel steering controller
`default_nettype none

package nwsc_pkg;

  // configuration register widths
  localparam int unsigned VOLT_W  = 9;
  localparam int unsigned PRESS_W = 9;
  localparam int unsigned STEP_W  = 10;
  localparam int unsigned LIMIT_W = 13;
  localparam int unsigned CLAMP_W = 14;
  localparam int unsigned TOL_W   = 10;
  localparam int unsigned CFG_W   = 14;
  localparam int unsigned CFG_IDX_W = 3;

  // result field widths
  localparam int unsigned DEMAND_W = 14;

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VOLT_THR  = 3'd0,
    CFG_PRESS_THR = 3'd1,
    CFG_STEP_STR  = 3'd2,
    CFG_STEP_OTH  = 3'd3,
    CFG_STEER_LIM = 3'd4,
    CFG_TKOFF_LIM = 3'd5,
    CFG_CLAMP     = 3'd6,
    CFG_TOL       = 3'd7
  } cfg_idx_e;

  // mode codes on the result word
  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_STEER = 2'd1;
  localparam logic [1:0] MODE_TKOFF = 2'd2;
  localparam logic [1:0] MODE_SAFE  = 2'd3;

  // pedal transfer in 1/10000 of travel
  localparam int unsigned PED_LEFT_END    = 4500;
  localparam int unsigned PED_RIGHT_START = 5500;
  localparam int unsigned PED_FULL        = 10000;
  localparam int unsigned PED_SPAN        = 4500;
  localparam int unsigned PED_HALF        = PED_SPAN / 2;
  localparam int unsigned DIFF_W          = 13;

  // limit * diff + half fits in PROD_W bits; divide by the span through a reciprocal
  localparam int unsigned PROD_W      = 26;
  localparam int unsigned RECIP_SHIFT = 39;
  localparam int unsigned RECIP_W     = 27;
  localparam logic [63:0] RECIP_FULL  =
      ((64'd1 << RECIP_SHIFT) + 64'(PED_SPAN) - 64'd1) / 64'(PED_SPAN);
  localparam logic [RECIP_W-1:0] PED_RECIP = RECIP_FULL[RECIP_W-1:0];

endpackage

`default_nettype wire

/* src/nwsc_scale.sv */
// two-stage pedal demand scaling: limit times pedal offset, rounded over the span
`default_nettype none

module nwsc_scale import nwsc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic [LIMIT_W-1:0] lim_i,
  input  wire logic [DIFF_W-1:0]  diff_i,
  output logic      [LIMIT_W-1:0] mag_o
);

  localparam int unsigned QW = PROD_W + RECIP_W;

  logic [PROD_W-1:0]  prod_d, prod_q;
  logic [QW-1:0]      quot_full;
  logic [LIMIT_W-1:0] mag_d, mag_q;

  assign prod_d = PROD_W'(lim_i) * PROD_W'(diff_i) + PROD_W'(PED_HALF);

  // exact floor division for any value below 2^PROD_W
  assign quot_full = QW'(prod_q) * QW'(PED_RECIP);
  assign mag_d     = quot_full[RECIP_SHIFT +: LIMIT_W];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      mag_q  <= mag_d;
    end
  end

  assign mag_o = mag_q;

endmodule

`default_nettype wire

/* src/nose_wheel_steering_control.sv */
// top level of the dual-channel nose wheel steering controller
`default_nettype none

// One control tick per input word, one word accepted every cycle unless the pipeline
// stalls. A word's result moves through registered stages: the mode latches and flags are
// formed at acceptance together with the pedal product, the second stage divides by
// the pedal span through a reciprocal multiply, and the last stage selects the larger
// channel demand and steps the wheel angle register, whose feedback loop closes inside
// that stage. The pipeline stalls as a whole only while a finished result waits to be
// taken. Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i
// and reset to their nominal values.
module nose_wheel_steering_control import nwsc_pkg::*; #(
  parameter int unsigned ANGLE_BITS = 15,
  parameter int unsigned PEDAL_BITS = 14
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration
  input  wire logic                         cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  wire logic [CFG_W-1:0]             cfg_wdata_i,
  // input word
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [VOLT_W-1:0]            volt_left_i,
  input  wire logic [VOLT_W-1:0]            volt_right_i,
  input  wire logic [PRESS_W-1:0]           press_one_i,
  input  wire logic [PRESS_W-1:0]           press_two_i,
  input  wire logic                         strut_compressed_i,
  input  wire logic                         enable_switch_i,
  input  wire logic                         mode_switch_i,
  input  wire logic [1:0]                   relay_ok_i,
  input  wire logic                         gear_released_i,
  input  wire logic [1:0]                   channel_fail_i,
  input  wire logic [PEDAL_BITS-1:0]        pedal_pos_i,
  // result word
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic signed [ANGLE_BITS-1:0]      wheel_angle_o,
  output logic signed [DEMAND_W-1:0]        demand_angle_o,
  output logic [1:0]                        mode_code_o,
  output logic                              ch1_steer_cmd_o,
  output logic                              ch1_takeoff_cmd_o,
  output logic                              ch2_steer_cmd_o,
  output logic                              ch2_takeoff_cmd_o,
  output logic                              ch1_ready_o,
  output logic                              ch2_ready_o,
  output logic                              lamp_first_o,
  output logic                              lamp_second_o,
  output logic                              breaker_on_o
);

  localparam int unsigned PW = (PEDAL_BITS > 14) ? PEDAL_BITS : 14;
  localparam int unsigned CW = (ANGLE_BITS > 14) ? ANGLE_BITS + 2 : 16;
  localparam logic signed [CW-1:0] AMAX = CW'((64'd1 << (ANGLE_BITS - 1)) - 64'd1);
  localparam logic signed [CW-1:0] AMIN = -AMAX - CW'(1);

  typedef struct packed {
    logic st1;
    logic to1;
    logic st2;
    logic to2;
    logic ready1;
    logic ready2;
    logic breaker;
    logic act1;
    logic act2;
    logic neg;
  } stage_t;

  // configuration registers
  logic [VOLT_W-1:0]  volt_thr_q;
  logic [PRESS_W-1:0] press_thr_q;
  logic [STEP_W-1:0]  step_str_q, step_oth_q;
  logic [LIMIT_W-1:0] steer_lim_q, tkoff_lim_q;
  logic [CLAMP_W-1:0] clamp_q;
  logic [TOL_W-1:0]   tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volt_thr_q  <= VOLT_W'(190);
      press_thr_q <= PRESS_W'(130);
      step_str_q  <= STEP_W'(16);
      step_oth_q  <= STEP_W'(18);
      steer_lim_q <= LIMIT_W'(5700);
      tkoff_lim_q <= LIMIT_W'(800);
      clamp_q     <= CLAMP_W'(6000);
      tol_q       <= TOL_W'(10);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_VOLT_THR:  volt_thr_q  <= cfg_wdata_i[VOLT_W-1:0];
        CFG_PRESS_THR: press_thr_q <= cfg_wdata_i[PRESS_W-1:0];
        CFG_STEP_STR:  step_str_q  <= cfg_wdata_i[STEP_W-1:0];
        CFG_STEP_OTH:  step_oth_q  <= cfg_wdata_i[STEP_W-1:0];
        CFG_STEER_LIM: steer_lim_q <= cfg_wdata_i[LIMIT_W-1:0];
        CFG_TKOFF_LIM: tkoff_lim_q <= cfg_wdata_i[LIMIT_W-1:0];
        CFG_CLAMP:     clamp_q     <= cfg_wdata_i[CLAMP_W-1:0];
        CFG_TOL:       tol_q       <= cfg_wdata_i[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic advance, accept;
  logic s1_valid_q, s2_valid_q, out_valid_q;

  assign advance    = !(out_valid_q && out_stall_i);
  assign accept     = advance && in_valid_i;
  assign in_stall_o = !advance;

  // acceptance stage: mode latches, flags, pedal offset
  logic pw1, pw2, on1;
  logic latch1_d, latch1_q, latch2_d, latch2_q, l2_pre;
  logic [PW-1:0]      ped;
  logic               ped_left, ped_right;
  logic [DIFF_W-1:0]  diff;
  logic [LIMIT_W-1:0] lim1, lim2;
  stage_t             s0, s1_q, s2_q;

  assign pw1 = volt_left_i >= volt_thr_q;
  assign pw2 = volt_right_i >= volt_thr_q;
  assign on1 = pw1 && enable_switch_i;

  always_comb begin
    if (!on1) begin
      latch1_d = 1'b0;
    end else if (mode_switch_i) begin
      latch1_d = 1'b1;
    end else if (!strut_compressed_i) begin
      latch1_d = 1'b0;
    end else begin
      latch1_d = latch1_q;
    end
  end

  // channel two: the strut holds the latch only while the channel is powered
  always_comb begin
    l2_pre = pw2 ? latch2_q : 1'b0;
    if (!enable_switch_i) begin
      latch2_d = 1'b0;
    end else if (mode_switch_i) begin
      latch2_d = 1'b1;
    end else if (!(pw2 && strut_compressed_i)) begin
      latch2_d = 1'b0;
    end else begin
      latch2_d = l2_pre;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch1_q <= 1'b0;
      latch2_q <= 1'b0;
    end else if (accept) begin
      latch1_q <= latch1_d;
      latch2_q <= latch2_d;
    end
  end

  assign ped       = PW'(pedal_pos_i);
  assign ped_left  = ped <= PW'(PED_LEFT_END);
  assign ped_right = (ped >= PW'(PED_RIGHT_START)) && (ped <= PW'(PED_FULL));

  always_comb begin
    if (ped_left) begin
      diff = DIFF_W'(PW'(PED_LEFT_END) - ped);
    end else if (ped_right) begin
      diff = DIFF_W'(ped - PW'(PED_RIGHT_START));
    end else begin
      diff = '0;
    end
  end

  always_comb begin
    s0.st1     = on1 && latch1_d;
    s0.to1     = on1 && !latch1_d;
    s0.st2     = enable_switch_i && latch2_d;
    s0.to2     = enable_switch_i && !latch2_d;
    s0.ready1  = on1 && relay_ok_i[0] && gear_released_i && !channel_fail_i[0];
    s0.ready2  = pw2 && enable_switch_i && relay_ok_i[1] && gear_released_i &&
                 !channel_fail_i[1];
    s0.breaker = on1;
    s0.act1    = on1 && !channel_fail_i[0] && (press_one_i >= press_thr_q);
    s0.act2    = pw2 && enable_switch_i && !channel_fail_i[1] &&
                 (press_two_i >= press_thr_q);
    s0.neg     = ped_left;
  end

  // a safe channel scales with a zero limit and so demands nothing
  assign lim1 = !s0.act1 ? '0 : (s0.st1 ? steer_lim_q : tkoff_lim_q);
  assign lim2 = !s0.act2 ? '0 : (s0.st2 ? steer_lim_q : tkoff_lim_q);

  logic [LIMIT_W-1:0] mag1, mag2;

  nwsc_scale u_scale1 (
    .clk_i  (clk_i),
    .en_i   (advance),
    .lim_i  (lim1),
    .diff_i (diff),
    .mag_o  (mag1)
  );

  nwsc_scale u_scale2 (
    .clk_i  (clk_i),
    .en_i   (advance),
    .lim_i  (lim2),
    .diff_i (diff),
    .mag_o  (mag2)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_q <= s0;
      s2_q <= s1_q;
    end
  end

  // last stage: demand select and wheel angle step
  logic                       safe, r1, r2, vp1, vp2, both, vp;
  logic [LIMIT_W-1:0]         mag_sel;
  logic signed [DEMAND_W-1:0] dem_sel, dem_d;
  logic [1:0]                 mode_d;
  logic signed [CW-1:0]       a_w, dem_w, err, abs_err, tol_w, stp_w, lim_w, nxt;
  logic signed [ANGLE_BITS-1:0] angle_d, angle_q;

  assign mag_sel = (mag1 >= mag2) ? mag1 : mag2;
  assign dem_sel = s2_q.neg ? -signed'(DEMAND_W'(mag_sel)) : signed'(DEMAND_W'(mag_sel));

  assign safe = !s2_q.act1 && !s2_q.act2;
  assign r1   = s2_q.act1 && s2_q.st1;
  assign r2   = s2_q.act2 && s2_q.st2;
  assign vp1  = s2_q.act1 && !s2_q.st1;
  assign vp2  = s2_q.act2 && !s2_q.st2;
  assign both = r1 && r2;
  assign vp   = !r1 && (vp1 || vp2);

  assign a_w     = CW'(angle_q);
  assign dem_w   = CW'(dem_sel);
  assign err     = a_w - dem_w;
  assign abs_err = (err < 0) ? -err : err;
  assign tol_w   = signed'(CW'(tol_q));
  assign stp_w   = signed'(CW'(both ? step_str_q : step_oth_q));
  assign lim_w   = signed'(CW'(clamp_q));

  always_comb begin
    if (abs_err >= tol_w) begin
      nxt = (err >= 0) ? a_w - stp_w : a_w + stp_w;
    end else begin
      nxt = a_w;
    end
    if (nxt >= lim_w) nxt = lim_w;
    if (nxt < -lim_w) nxt = -lim_w;
    if (nxt > AMAX) nxt = AMAX;
    if (nxt < AMIN) nxt = AMIN;

    if (safe) begin
      angle_d = '0;
      dem_d   = '0;
      mode_d  = MODE_SAFE;
    end else begin
      angle_d = nxt[ANGLE_BITS-1:0];
      dem_d   = dem_sel;
      mode_d  = both ? MODE_STEER : (vp ? MODE_TKOFF : MODE_NONE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
    end else if (advance && s2_valid_q) begin
      angle_q <= angle_d;
    end
  end

  logic signed [DEMAND_W-1:0] dem_q;
  logic [1:0] mode_q;
  stage_t     out_q;

  always_ff @(posedge clk_i) begin
    if (advance && s2_valid_q) begin
      dem_q  <= dem_d;
      mode_q <= mode_d;
      out_q  <= s2_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign wheel_angle_o     = angle_q;
  assign demand_angle_o    = dem_q;
  assign mode_code_o       = mode_q;
  assign ch1_steer_cmd_o   = out_q.st1;
  assign ch1_takeoff_cmd_o = out_q.to1;
  assign ch2_steer_cmd_o   = out_q.st2;
  assign ch2_takeoff_cmd_o = out_q.to2;
  assign ch1_ready_o       = out_q.ready1;
  assign ch2_ready_o       = out_q.ready2;
  assign lamp_first_o      = out_q.st1;
  assign lamp_second_o     = !out_q.st1 && out_q.st2;
  assign breaker_on_o      = out_q.breaker;

`ifndef SYNTHESIS
  a_safe_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && mode_code_o == MODE_SAFE) |-> (wheel_angle_o == 0 && demand_angle_o == 0))
    else $error("safe mode with nonzero angle or demand");

  a_angle_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (CW'(wheel_angle_o) <= lim_w && CW'(wheel_angle_o) >= -lim_w))
    else $error("wheel angle beyond clamp");

  a_ch1_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !breaker_on_o) |-> (!ch1_steer_cmd_o && !ch1_takeoff_cmd_o))
    else $error("channel one command while breaker off");

  a_angle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance && s2_valid_q) |=> $stable(angle_q))
    else $error("wheel angle moved without a word");
`endif

endmodule

`default_nettype wire
